### rtl/tbl_pkg.sv
// Shared types and constants for the threshold blob labeller.
// Holds the payload structs, the controller state type and the command and status bundles.
// Depends on nothing.
package tbl_pkg;

   // Default image limits of the label memory.
   localparam int MAX_WIDTH_DEFAULT  = 128;
   localparam int MAX_HEIGHT_DEFAULT = 128;

   // Operation codes of a request.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_HEIGHT    = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] THRESHOLD_RESET = 8'd100;
   localparam logic [7:0] WIDTH_RESET     = 8'd128;
   localparam logic [7:0] HEIGHT_RESET    = 8'd128;

   typedef struct packed {
      logic       operation;
      logic [7:0] gray_level;
   } req_payload_type;

   typedef struct packed {
      logic [6:0]  column;
      logic [6:0]  row_index;
      logic [12:0] blob_number;
      logic        blob_end;
      logic        all_done;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_READY,
      ST_DONE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_NB_RD,
      ST_NB_CHK,
      ST_FIND_RD,
      ST_FIND_CHK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ld_wr;
      logic ld_restart;
      logic scan_clr;
      logic scan_adv;
      logic scan_rpos;
      logic lbl_rd_nb;
      logic mark_scan;
      logic mark_nb;
      logic push_scan;
      logic push_nb;
      logic pop;
      logic pt_latch;
      logic nb_clr;
      logic nb_inc;
      logic nb_latch;
      logic blobs_clr;
      logic blobs_inc;
      logic rblob_clr;
      logic rblob_inc;
      logic rpos_clr;
      logic rpos_save;
      logic found_set;
      logic rsp_pt_cur;
      logic rsp_pt_held;
      logic rsp_end;
      logic rsp_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ld_last;
      logic scan_last;
      logic lbl_one;
      logic lbl_match;
      logic stack_empty;
      logic nb_valid;
      logic nb_last;
      logic found;
      logic rblob_ge;
      logic geo_wr;
   } status_type;

endpackage

### rtl/threshold_blob_labeler_top.sv
// Top level of the threshold blob labeller.
// Instantiates tbl_ctrl and tbl_datapath; depends on tbl_pkg.
//
// Pixels are loaded one per cycle in raster order with operation 0; each load returns no
// result. The load of the last pixel starts labelling, during which busy stays high: the
// scan reads and checks each pixel, and every filled pixel adds a pop and up to four
// neighbour reads of the label memory, which has one read port. A fetch (operation 1)
// returns exactly one result on rsp_valid for one cycle; the receiver cannot stall it. A
// fetch walks the label memory from the position saved by the previous fetch, past the
// point it returns to the next point of the current blob or to the last pixel, which tells
// it whether that point ends the blob. A fetch while loading or after the last point
// returns all_done in the following cycle. Configuration writes are accepted only while the
// block is idle and start is low, so they never overlap labelling, a readout walk or a
// request transfer.
module threshold_blob_labeler_top import tbl_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   tbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_payload.operation),
      .status    (status),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Only accepted configuration transfers reach the registers.
   tbl_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .gray_level  (req_payload.gray_level),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/tbl_ctrl.sv
// Controller state machine of the threshold blob labeller.
// Sequences loading, flood fill labelling and point readout.
// Depends on tbl_pkg.
module tbl_ctrl import tbl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_op,
   input  status_type status,
   output logic       busy,
   output logic       csr_ready,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      idle;

   assign idle = (state_ff == ST_LOAD) || (state_ff == ST_READY) || (state_ff == ST_DONE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD, ST_READY, ST_DONE: begin
            if (status.geo_wr) begin
               state_in = ST_LOAD;
            end else if (start) begin
               if (req_op == OP_LOAD) begin
                  state_in = status.ld_last ? ST_SCAN_RD : ST_LOAD;
               end else if (state_ff == ST_READY) begin
                  state_in = status.rblob_ge ? ST_DONE : ST_FIND_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.lbl_one) begin
               state_in = ST_POP_RD;
            end else if (status.scan_last) begin
               state_in = ST_READY;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP_RD: begin
            if (!status.stack_empty) begin
               state_in = ST_POP_WAIT;
            end else if (status.scan_last) begin
               state_in = ST_READY;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP_WAIT: begin
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            if (status.nb_valid) begin
               state_in = ST_NB_CHK;
            end else if (status.nb_last) begin
               state_in = ST_POP_RD;
            end
         end
         ST_NB_CHK: begin
            state_in = status.nb_last ? ST_POP_RD : ST_NB_RD;
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (status.found && status.lbl_match) begin
               state_in = ST_READY;
            end else if (status.scan_last) begin
               state_in = (status.found || status.lbl_match) ? ST_READY : ST_DONE;
            end else begin
               state_in = ST_FIND_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      busy      = !idle;
      csr_ready = idle && !start;
      case (state_ff)
         ST_LOAD, ST_READY, ST_DONE: begin
            if (!status.geo_wr && start) begin
               if (req_op == OP_LOAD) begin
                  cmd.ld_wr      = 1'b1;
                  cmd.ld_restart = (state_ff != ST_LOAD);
                  if (status.ld_last) begin
                     cmd.scan_clr  = 1'b1;
                     cmd.blobs_clr = 1'b1;
                  end
               end else if (state_ff == ST_READY && !status.rblob_ge) begin
                  cmd.scan_rpos = 1'b1;
               end else begin
                  cmd.rsp_done = 1'b1;
               end
            end
         end
         ST_SCAN_CHK: begin
            if (status.lbl_one) begin
               cmd.mark_scan = 1'b1;
               cmd.push_scan = 1'b1;
            end else if (status.scan_last) begin
               cmd.rblob_clr = 1'b1;
               cmd.rpos_clr  = 1'b1;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         ST_POP_RD: begin
            if (!status.stack_empty) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.blobs_inc = 1'b1;
               if (status.scan_last) begin
                  cmd.rblob_clr = 1'b1;
                  cmd.rpos_clr  = 1'b1;
               end else begin
                  cmd.scan_adv = 1'b1;
               end
            end
         end
         ST_POP_WAIT: begin
            cmd.pt_latch = 1'b1;
            cmd.nb_clr   = 1'b1;
         end
         ST_NB_RD: begin
            if (status.nb_valid) begin
               cmd.lbl_rd_nb = 1'b1;
               cmd.nb_latch  = 1'b1;
            end else if (!status.nb_last) begin
               cmd.nb_inc = 1'b1;
            end
         end
         ST_NB_CHK: begin
            if (status.lbl_one) begin
               cmd.mark_nb = 1'b1;
               cmd.push_nb = 1'b1;
            end
            cmd.nb_inc = !status.nb_last;
         end
         ST_FIND_CHK: begin
            if (status.found) begin
               if (status.lbl_match) begin
                  cmd.rsp_pt_held = 1'b1;
                  cmd.rpos_save   = 1'b1;
               end else if (status.scan_last) begin
                  cmd.rsp_pt_held = 1'b1;
                  cmd.rsp_end     = 1'b1;
                  cmd.rblob_inc   = 1'b1;
                  cmd.rpos_clr    = 1'b1;
               end else begin
                  cmd.scan_adv = 1'b1;
               end
            end else if (status.lbl_match) begin
               if (status.scan_last) begin
                  cmd.rsp_pt_cur = 1'b1;
                  cmd.rsp_end    = 1'b1;
                  cmd.rblob_inc  = 1'b1;
                  cmd.rpos_clr   = 1'b1;
               end else begin
                  cmd.found_set = 1'b1;
                  cmd.scan_adv  = 1'b1;
               end
            end else if (status.scan_last) begin
               cmd.rsp_done = 1'b1;
            end else begin
               cmd.scan_adv = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/tbl_datapath.sv
// Datapath of the threshold blob labeller: configuration, label memory, fill stack,
// cursors, counters and the result register.
// Depends on tbl_pkg.
module tbl_datapath import tbl_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      gray_level,
   input  logic            csr_valid,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_data,
   input  cmd_type         cmd,
   output status_type      status,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW  = $clog2(CAP + 1);
   localparam int BW  = $clog2(CAP / 2 + 2);
   localparam int LW  = $clog2(CAP / 2 + 3);
   localparam int PW  = XW + YW;

   // Configuration registers.
   logic [7:0] threshold_ff, width_ff, height_ff;
   logic       geo_wr;

   assign geo_wr = csr_valid && ((csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_WIDTH:     width_ff     <= csr_data;
            CSR_HEIGHT:    height_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Last column and row in use, with the geometry limited to the memory.
   logic [XW-1:0] x_last;
   logic [YW-1:0] y_last;

   always_comb begin
      int wv;
      int hv;
      wv = (width_ff == 8'd0) ? 1 : ((int'(width_ff) > MAX_WIDTH) ? MAX_WIDTH : int'(width_ff));
      hv = (height_ff == 8'd0) ? 1 :
           ((int'(height_ff) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_ff));
      x_last = XW'(wv - 1);
      y_last = YW'(hv - 1);
   end

   // Load cursor.
   logic [XW-1:0] lx_ff, lx_in, lx_eff;
   logic [YW-1:0] ly_ff, ly_in, ly_eff;

   assign lx_eff = cmd.ld_restart ? '0 : lx_ff;
   assign ly_eff = cmd.ld_restart ? '0 : ly_ff;

   always_comb begin
      lx_in = lx_ff;
      ly_in = ly_ff;
      if (geo_wr) begin
         lx_in = '0;
         ly_in = '0;
      end else if (cmd.ld_wr) begin
         if (lx_eff == x_last) begin
            lx_in = '0;
            ly_in = ly_eff + YW'(1);
         end else begin
            lx_in = lx_eff + XW'(1);
            ly_in = ly_eff;
         end
      end
   end

   // Scan cursor, shared by labelling and readout.
   logic [XW-1:0] sx_ff, sx_in, rx_ff, pfx_ff;
   logic [YW-1:0] sy_ff, sy_in, ry_ff, pfy_ff;
   logic          scan_last, found_ff;

   assign scan_last = (sx_ff == x_last) && (sy_ff == y_last);

   always_comb begin
      sx_in = sx_ff;
      sy_in = sy_ff;
      if (cmd.scan_clr) begin
         sx_in = '0;
         sy_in = '0;
      end else if (cmd.scan_rpos) begin
         sx_in = rx_ff;
         sy_in = ry_ff;
      end else if (cmd.scan_adv) begin
         if (sx_ff == x_last) begin
            sx_in = '0;
            sy_in = sy_ff + YW'(1);
         end else begin
            sx_in = sx_ff + XW'(1);
         end
      end
   end

   // Popped point and neighbour selection.
   logic [XW-1:0] px_ff, nx_ff, nbx;
   logic [YW-1:0] py_ff, ny_ff, nby;
   logic [1:0]    nb_ff;
   logic          nb_valid;

   always_comb begin
      nbx      = px_ff;
      nby      = py_ff;
      nb_valid = 1'b0;
      case (nb_ff)
         2'd0: begin
            nbx      = px_ff - XW'(1);
            nb_valid = (px_ff != '0);
         end
         2'd1: begin
            nbx      = px_ff + XW'(1);
            nb_valid = (px_ff != x_last);
         end
         2'd2: begin
            nby      = py_ff - YW'(1);
            nb_valid = (py_ff != '0);
         end
         2'd3: begin
            nby      = py_ff + YW'(1);
            nb_valid = (py_ff != y_last);
         end
         default: begin
         end
      endcase
   end

   // Counters of blobs.
   logic [BW-1:0] blobs_ff, rblob_ff;
   logic [LW-1:0] mark;

   assign mark = LW'(blobs_ff) + LW'(2);

   // Label memory with registered read data.
   logic [LW-1:0] label_mem [CAP];
   logic [LW-1:0] lbl_q_ff;
   logic [AW-1:0] lbl_wa, lbl_ra;
   logic [LW-1:0] lbl_wd;
   logic          lbl_we;

   always_comb begin
      lbl_we = cmd.ld_wr || cmd.mark_scan || cmd.mark_nb;
      lbl_wd = mark;
      lbl_wa = AW'(sy_ff) * AW'(MAX_WIDTH) + AW'(sx_ff);
      if (cmd.ld_wr) begin
         lbl_wd = LW'(gray_level > threshold_ff);
         lbl_wa = AW'(ly_eff) * AW'(MAX_WIDTH) + AW'(lx_eff);
      end else if (cmd.mark_nb) begin
         lbl_wa = AW'(ny_ff) * AW'(MAX_WIDTH) + AW'(nx_ff);
      end
      if (cmd.lbl_rd_nb) begin
         lbl_ra = AW'(nby) * AW'(MAX_WIDTH) + AW'(nbx);
      end else begin
         lbl_ra = AW'(sy_ff) * AW'(MAX_WIDTH) + AW'(sx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         label_mem[lbl_wa] <= lbl_wd;
      end
      lbl_q_ff <= label_mem[lbl_ra];
   end

   // Fill stack of pending points, held as row and column.
   logic [PW-1:0] stack_mem [CAP];
   logic [PW-1:0] stack_q_ff;
   logic [SW-1:0] sp_ff, sp_dec;
   logic          push;

   assign sp_dec = sp_ff - SW'(1);
   assign push   = cmd.push_scan || cmd.push_nb;

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[sp_ff[AW-1:0]] <= cmd.push_nb ? {ny_ff, nx_ff} : {sy_ff, sx_ff};
      end
      if (cmd.pop) begin
         stack_q_ff <= stack_mem[sp_dec[AW-1:0]];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff     <= '0;
         ly_ff     <= '0;
         sx_ff     <= '0;
         sy_ff     <= '0;
         rx_ff     <= '0;
         ry_ff     <= '0;
         sp_ff     <= '0;
         nb_ff     <= '0;
         blobs_ff  <= '0;
         rblob_ff  <= '0;
         found_ff  <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         if (push) begin
            sp_ff <= sp_ff + SW'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_dec;
         end
         if (cmd.nb_clr) begin
            nb_ff <= '0;
         end else if (cmd.nb_inc) begin
            nb_ff <= nb_ff + 2'd1;
         end
         if (cmd.blobs_clr) begin
            blobs_ff <= '0;
         end else if (cmd.blobs_inc) begin
            blobs_ff <= blobs_ff + BW'(1);
         end
         if (cmd.rblob_clr) begin
            rblob_ff <= '0;
         end else if (cmd.rblob_inc) begin
            rblob_ff <= rblob_ff + BW'(1);
         end
         if (cmd.rpos_clr) begin
            rx_ff <= '0;
            ry_ff <= '0;
         end else if (cmd.rpos_save) begin
            rx_ff <= sx_ff;
            ry_ff <= sy_ff;
         end
         if (cmd.scan_rpos) begin
            found_ff <= 1'b0;
         end else if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
         rsp_valid <= cmd.rsp_pt_cur || cmd.rsp_pt_held || cmd.rsp_done;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.pt_latch) begin
         px_ff <= stack_q_ff[XW-1:0];
         py_ff <= stack_q_ff[PW-1:XW];
      end
      if (cmd.nb_latch) begin
         nx_ff <= nbx;
         ny_ff <= nby;
      end
      if (cmd.found_set) begin
         pfx_ff <= sx_ff;
         pfy_ff <= sy_ff;
      end
   end

   // Result register.
   logic [31:0] out_x32, out_y32, out_b32;

   assign out_x32 = cmd.rsp_pt_held ? 32'(pfx_ff) : 32'(sx_ff);
   assign out_y32 = cmd.rsp_pt_held ? 32'(pfy_ff) : 32'(sy_ff);
   assign out_b32 = 32'(rblob_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_done) begin
         rsp_payload <= '{column: '0, row_index: '0, blob_number: '0,
                          blob_end: 1'b0, all_done: 1'b1};
      end else if (cmd.rsp_pt_cur || cmd.rsp_pt_held) begin
         rsp_payload.column      <= out_x32[6:0];
         rsp_payload.row_index   <= out_y32[6:0];
         rsp_payload.blob_number <= out_b32[12:0];
         rsp_payload.blob_end    <= cmd.rsp_end;
         rsp_payload.all_done    <= 1'b0;
      end
   end

   // Status to the controller.
   always_comb begin
      status.ld_last     = (lx_eff == x_last) && (ly_eff == y_last);
      status.scan_last   = scan_last;
      status.lbl_one     = (lbl_q_ff == LW'(1));
      status.lbl_match   = (lbl_q_ff == (LW'(rblob_ff) + LW'(2)));
      status.stack_empty = (sp_ff == '0);
      status.nb_valid    = nb_valid;
      status.nb_last     = (nb_ff == 2'd3);
      status.found       = found_ff;
      status.rblob_ge    = (rblob_ff >= blobs_ff);
      status.geo_wr      = geo_wr;
   end

endmodule

### verif/threshold_blob_labeler_top_tb.sv
// Self-checking testbench for the threshold blob labeller top level.
// Drives pixel loads, point fetches and register writes, and checks every result
// against an in-bench prediction. Depends on tbl_pkg and threshold_blob_labeler_top.
`timescale 1ns / 100ps

module threshold_blob_labeler_top_tb;
   import tbl_pkg::*;

   localparam int MAX_W      = MAX_WIDTH_DEFAULT;
   localparam int MAX_H      = MAX_HEIGHT_DEFAULT;
   localparam int PIXELS     = MAX_W * MAX_H;
   localparam int CYCLE_CAP  = 6000000;
   localparam int RAND_ITEMS = 1800;

   // Label codes held in the predicted label memory.
   localparam logic [13:0] LBL_BACKGROUND = 14'd0;
   localparam logic [13:0] LBL_UNLABELLED = 14'd1;
   localparam logic [13:0] LBL_FIRST_BLOB = 14'd2;

   // Readout phases of the prediction.
   typedef enum logic [1:0] {PH_LOADING, PH_READOUT, PH_FINISHED} phase_type;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [7:0]      csr_data;

   threshold_blob_labeler_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predicted state of the labeller.
   logic [13:0] lbl_mem [PIXELS];
   logic [13:0] fill_mem [PIXELS];
   logic [14:0] loaded_count;
   logic [13:0] blob_count;
   logic [13:0] cur_blob;
   logic [14:0] cur_pos;
   phase_type   cur_phase;
   logic [7:0]  cfg_threshold;
   logic [7:0]  cfg_width;
   logic [7:0]  cfg_height;

   rsp_payload_type point_q[$];
   int unsigned     mismatches;
   int unsigned     cycle_count;
   int unsigned     items_sent;
   bit              steady_drive;

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Run-time guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int dim_in_use(logic [7:0] v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic int first_with_mark(int from, logic [13:0] mark, int total);
      for (int p = from; p < total; p++)
         if (lbl_mem[p] == mark) return p;
      return total;
   endfunction

   // Flood fill of every unlabelled pixel, seeds in raster order.
   function automatic void label_regions();
      int w;
      int total;
      int depth;
      int p;
      int q;
      int nbr [4];
      int n;
      logic [13:0] mark;
      w = dim_in_use(cfg_width, MAX_W);
      total = w * dim_in_use(cfg_height, MAX_H);
      blob_count = 0;
      for (int s = 0; s < total; s++) begin
         if (lbl_mem[s] == LBL_UNLABELLED) begin
            mark = blob_count + LBL_FIRST_BLOB;
            depth = 0;
            lbl_mem[s] = mark;
            fill_mem[depth++] = 14'(s);
            while (depth > 0) begin
               p = fill_mem[--depth];
               n = 0;
               if (p % w > 0) nbr[n++] = p - 1;
               if (p % w + 1 < w) nbr[n++] = p + 1;
               if (p >= w) nbr[n++] = p - w;
               if (p + w < total) nbr[n++] = p + w;
               for (int k = 0; k < n; k++) begin
                  q = nbr[k];
                  if (lbl_mem[q] == LBL_UNLABELLED && depth < PIXELS) begin
                     lbl_mem[q] = mark;
                     fill_mem[depth++] = 14'(q);
                  end
               end
            end
            blob_count++;
         end
      end
      cur_blob = 0;
      cur_pos = 0;
      cur_phase = PH_READOUT;
   endfunction

   function automatic void predict_config(logic [1:0] idx, logic [7:0] v);
      if (idx == CSR_THRESHOLD) begin
         cfg_threshold = v;
      end else if (idx == CSR_WIDTH || idx == CSR_HEIGHT) begin
         if (idx == CSR_WIDTH) cfg_width = v;
         else cfg_height = v;
         loaded_count = 0;
         cur_phase = PH_LOADING;
      end
   endfunction

   // Applies one accepted request; a fetch queues the result it should return.
   function automatic void predict_request(req_payload_type r);
      int w;
      int total;
      int p;
      int q;
      logic [13:0] mark;
      rsp_payload_type pt;
      w = dim_in_use(cfg_width, MAX_W);
      total = w * dim_in_use(cfg_height, MAX_H);
      if (r.operation == OP_LOAD) begin
         if (cur_phase != PH_LOADING) begin
            cur_phase = PH_LOADING;
            loaded_count = 0;
         end
         if (loaded_count < total)
            lbl_mem[loaded_count] = (r.gray_level > cfg_threshold) ? LBL_UNLABELLED
                                                                   : LBL_BACKGROUND;
         loaded_count++;
         if (loaded_count >= total) label_regions();
         return;
      end
      pt = '0;
      pt.all_done = 1'b1;
      if (cur_phase == PH_READOUT) begin
         mark = cur_blob + LBL_FIRST_BLOB;
         p = (cur_blob < blob_count) ? first_with_mark(cur_pos, mark, total) : total;
         if (p >= total) begin
            cur_phase = PH_FINISHED;
         end else begin
            pt.column = 7'(p % w);
            pt.row_index = 7'(p / w);
            pt.blob_number = cur_blob[12:0];
            pt.all_done = 1'b0;
            q = first_with_mark(p + 1, mark, total);
            if (q >= total) begin
               pt.blob_end = 1'b1;
               cur_blob++;
               cur_pos = 0;
            end else begin
               cur_pos = 15'(q);
            end
         end
      end
      point_q.insert(point_q.size(), pt);
   endfunction

   function automatic void check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         mismatches++;
      end
   endfunction

   // Every returned point is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid) begin
         if (point_q.size() == 0) begin
            $error("unexpected result: expected none, actual %h", rsp_payload);
            mismatches++;
         end else begin
            want = point_q.pop_front();
            check_field("column", want.column, rsp_payload.column);
            check_field("row_index", want.row_index, rsp_payload.row_index);
            check_field("blob_number", want.blob_number, rsp_payload.blob_number);
            check_field("blob_end", want.blob_end, rsp_payload.blob_end);
            check_field("all_done", want.all_done, rsp_payload.all_done);
         end
      end
   end

   // Presents one request and waits for its transfer.
   task automatic send_item(logic op, logic [7:0] gray);
      req_payload_type r;
      if (!steady_drive && $urandom_range(99) < 13) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      r.operation = op;
      r.gray_level = gray;
      req_payload <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(r);
      items_sent++;
   endtask

   // Lets every pending result arrive and labelling finish.
   task automatic settle();
      start <= 1'b0;
      while (point_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [7:0] v);
      settle();
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      predict_config(idx, v);
   endtask

   // Fetches until the end marker has been predicted, then once more.
   task automatic read_all_points();
      while (cur_phase == PH_READOUT) send_item(OP_FETCH, 8'($urandom));
      send_item(OP_FETCH, 8'($urandom));
   endtask

   // Small image with a U-shaped blob, a lone corner blob and threshold edges.
   task automatic test_directed_image();
      logic [7:0] pix [16] = '{255, 0, 101, 100,
                               255, 0, 255, 0,
                               255, 255, 255, 0,
                               0, 0, 0, 230};
      write_register(CSR_THRESHOLD, 8'd100);
      write_register(CSR_WIDTH, 8'd4);
      write_register(CSR_HEIGHT, 8'd4);
      send_item(OP_FETCH, 8'd0);
      for (int i = 0; i < 16; i++) send_item(OP_LOAD, pix[i]);
      read_all_points();
   endtask

   // Tallest image, sparse bright pixels and the far corner set.
   task automatic test_full_geometry();
      int total;
      total = 4 * MAX_H;
      write_register(CSR_THRESHOLD, 8'd254);
      write_register(CSR_WIDTH, 8'd4);
      write_register(CSR_HEIGHT, 8'd128);
      steady_drive = 1'b1;
      for (int p = 0; p < total; p++)
         send_item(OP_LOAD, (p % 37 == 5 || p == total - 1) ? 8'd255 : 8'd254);
      steady_drive = 1'b0;
      read_all_points();
   endtask

   // Out-of-range geometry: zero width and an over-wide single row.
   task automatic test_clamped_geometry();
      write_register(CSR_THRESHOLD, 8'd0);
      write_register(CSR_WIDTH, 8'd0);
      write_register(CSR_HEIGHT, 8'd3);
      for (int i = 0; i < 3; i++) send_item(OP_LOAD, i[7:0]);
      read_all_points();
      write_register(CSR_WIDTH, 8'd255);
      write_register(CSR_HEIGHT, 8'd1);
      for (int i = 0; i < 128; i++) send_item(OP_LOAD, (i % 3 == 0) ? 8'd0 : 8'd77);
      read_all_points();
   endtask

   // Random images of small size, with noise and interrupted loads.
   task automatic test_random_images();
      int w;
      int h;
      int thr;
      int n;
      while (items_sent < RAND_ITEMS) begin
         steady_drive = (items_sent > 900 && items_sent < 1200);
         case ($urandom_range(9))
            0: thr = 0;
            1: thr = 255;
            default: thr = $urandom_range(255);
         endcase
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 10);
         write_register(CSR_THRESHOLD, thr[7:0]);
         if ($urandom_range(1)) begin
            write_register(CSR_WIDTH, w[7:0]);
            write_register(CSR_HEIGHT, h[7:0]);
         end else begin
            write_register(CSR_HEIGHT, h[7:0]);
            write_register(CSR_WIDTH, w[7:0]);
         end
         // Occasionally abandon a partial image by rewriting the geometry.
         if ($urandom_range(7) == 0) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) send_item(OP_LOAD, 8'($urandom));
            write_register(CSR_WIDTH, w[7:0]);
         end
         for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(19) == 0) send_item(OP_FETCH, 8'($urandom));
            send_item(OP_LOAD, ($urandom_range(3) == 0) ? 8'($urandom)
                               : 8'(thr + $urandom_range(0, 1) * 2 - 1));
         end
         // Sometimes start a new image part way through the readout.
         if ($urandom_range(5) == 0) begin
            send_item(OP_FETCH, 8'($urandom));
            for (int i = 0; i < w * h; i++) send_item(OP_LOAD, 8'($urandom));
         end
         read_all_points();
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_data <= '0;
      cycle_count = 0;
      mismatches = 0;
      items_sent = 0;
      steady_drive = 1'b0;
      loaded_count = 0;
      blob_count = 0;
      cur_blob = 0;
      cur_pos = 0;
      cur_phase = PH_LOADING;
      cfg_threshold = THRESHOLD_RESET;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_image();
      test_clamped_geometry();
      test_full_geometry();
      test_random_images();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && point_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
